[rtl/bas_pkg.sv]
// ----------------------------------------------------------------------------
// bas_pkg: shared definitions of the bilinear alpha sampler
// Widths, fixed-point constants, register indexes and the pipeline item types.
// ----------------------------------------------------------------------------
package bas_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 24;
	localparam int DIM_W = 11;
	localparam int ALPHA_W = 16;
	localparam int INDEX_W = 16;
	localparam int TEXEL_CAPACITY_DEF = 65536;

	// Remainder steps resolved per pipeline stage.
	localparam int REM_STEPS = 4;

	// Scaled coordinate, integer texel coordinate and the width of the wrap dividend.
	localparam int XF_W = COORD_W + DIM_W + 2;
	localparam int IC_W = XF_W - FRAC_BITS;
	localparam int WRAP_W = IC_W + DIM_W;
	localparam int ADDR_FULL_W = 2 * DIM_W;

	// Blend arithmetic.
	localparam int WT_W = FRAC_BITS + 1;
	localparam int PROD_W = ALPHA_W + WT_W;
	localparam int ACC_W = PROD_W + WT_W;
	localparam int BLEND_LAT = 4;

	localparam logic signed [XF_W-1:0] FIX_ONE = XF_W'(64'd1 << FRAC_BITS);
	localparam logic signed [XF_W-1:0] FIX_HALF = XF_W'(64'd1 << (FRAC_BITS - 1));
	localparam logic [WT_W-1:0] WT_ONE = WT_W'(64'd1 << FRAC_BITS);

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic is_sample;
		logic [INDEX_W-1:0] texel_index;
		logic [ALPHA_W-1:0] texel_alpha;
		logic [FRAC_BITS-1:0] frac_x;
		logic [FRAC_BITS-1:0] frac_y;
	} bas_item_t;

	typedef struct packed {
		logic is_sample;
		logic [FRAC_BITS-1:0] frac_x;
		logic [FRAC_BITS-1:0] frac_y;
	} bas_tap_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] a00;
		logic [ALPHA_W-1:0] a10;
		logic [ALPHA_W-1:0] a01;
		logic [ALPHA_W-1:0] a11;
	} bas_quad_t;

endpackage

[rtl/bas_rem_pipe.sv]
// ----------------------------------------------------------------------------
// bas_rem_pipe: pipelined restoring remainder
// Reduces several unsigned dividends by their own divisors, a few quotient
// bits per stage, and carries a side payload along with each transaction.
// ----------------------------------------------------------------------------
module bas_rem_pipe #(
	parameter int LANES = 1,
	parameter int DW = 32,
	parameter int DVW = 11,
	parameter int SW = 1,
	localparam int NS = (DW + bas_pkg::REM_STEPS - 1) / bas_pkg::REM_STEPS,
	localparam int PW = NS * bas_pkg::REM_STEPS,
	localparam int RW = DVW + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [LANES-1:0][DVW-1:0]  divisor,
	input  logic                       in_valid,
	input  logic [LANES-1:0][DW-1:0]   dividend,
	input  logic [SW-1:0]              in_side,
	output logic                       out_valid,
	output logic [LANES-1:0][DVW-1:0]  remainder,
	output logic [SW-1:0]              out_side
);
	import bas_pkg::*;

	function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] r, input logic b,
			input logic [DVW-1:0] d);
		logic [RW-1:0] t;
		t = {r[DVW-1:0], b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t;
	endfunction

	logic                      valid_s [1:NS];
	logic [LANES-1:0][RW-1:0]  rem_s   [1:NS];
	logic [LANES-1:0][PW-1:0]  num_s   [1:NS];
	logic [SW-1:0]             side_s  [1:NS];

	logic [LANES-1:0][RW-1:0]  rem_in  [0:NS-1];
	logic [LANES-1:0][PW-1:0]  num_in  [0:NS-1];
	logic [LANES-1:0][RW-1:0]  rem_nx  [0:NS-1];
	logic [LANES-1:0][PW-1:0]  num_nx  [0:NS-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_in[0][l] = '0;
			num_in[0][l] = PW'(dividend[l]);
		end
		for (int k = 1; k < NS; k++) begin
			rem_in[k] = rem_s[k];
			num_in[k] = num_s[k];
		end
	end

	// The dividend is shifted in MSB first; the partial remainder stays below the divisor.
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_nx[k][l] = rem_in[k][l];
				num_nx[k][l] = num_in[k][l];
				for (int j = 0; j < REM_STEPS; j++) begin
					rem_nx[k][l] = rem_step(rem_nx[k][l], num_nx[k][l][PW-1], divisor[l]);
					num_nx[k][l] = num_nx[k][l] << 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= in_side;
		for (int k = 2; k <= NS; k++) begin
			side_s[k] <= side_s[k-1];
		end
		for (int k = 0; k < NS; k++) begin
			rem_s[k+1] <= rem_nx[k];
			num_s[k+1] <= num_nx[k];
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			remainder[l] = rem_s[NS][l][DVW-1:0];
		end
	end

	assign out_valid = valid_s[NS];
	assign out_side = side_s[NS];

endmodule

[rtl/bas_addr.sv]
// ----------------------------------------------------------------------------
// bas_addr: neighbor address generation
// Forms the second column and row of the footprint, the four linear texel
// addresses, and folds them into the store's capacity.
// ----------------------------------------------------------------------------
module bas_addr #(
	parameter int TEXEL_CAPACITY = bas_pkg::TEXEL_CAPACITY_DEF,
	localparam int ADDR_W = $clog2(TEXEL_CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bas_pkg::DIM_W-1:0]     dim_w,
	input  logic [bas_pkg::DIM_W-1:0]     dim_h,
	input  logic                          in_valid,
	input  bas_pkg::bas_item_t            in_item,
	input  logic [bas_pkg::DIM_W-1:0]     in_x0,
	input  logic [bas_pkg::DIM_W-1:0]     in_y0,
	output logic                          out_valid,
	output bas_pkg::bas_item_t            out_item,
	output logic [3:0][ADDR_W-1:0]        out_addr
);
	import bas_pkg::*;

	logic [DIM_W:0]           x_inc;
	logic [DIM_W:0]           y_inc;
	logic [DIM_W-1:0]         x1_c;
	logic [DIM_W-1:0]         y1_c;

	logic                     valid_s1;
	bas_item_t                item_s1;
	logic [DIM_W-1:0]         x0_s1;
	logic [DIM_W-1:0]         x1_s1;
	logic [ADDR_FULL_W-1:0]   row0_s1;
	logic [ADDR_FULL_W-1:0]   row1_s1;

	logic                             valid_s2;
	bas_item_t                        item_s2;
	logic [3:0][ADDR_FULL_W-1:0]      full_s2;

	// The neighbor past the last column or row wraps back to zero.
	always_comb begin
		x_inc = (DIM_W+1)'(in_x0) + (DIM_W+1)'(1);
		y_inc = (DIM_W+1)'(in_y0) + (DIM_W+1)'(1);
		x1_c = (x_inc == {1'b0, dim_w}) ? '0 : x_inc[DIM_W-1:0];
		y1_c = (y_inc == {1'b0, dim_h}) ? '0 : y_inc[DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		x0_s1 <= in_x0;
		x1_s1 <= x1_c;
		row0_s1 <= ADDR_FULL_W'(in_y0) * ADDR_FULL_W'(dim_w);
		row1_s1 <= ADDR_FULL_W'(y1_c) * ADDR_FULL_W'(dim_w);
		item_s2 <= item_s1;
		full_s2[0] <= row0_s1 + ADDR_FULL_W'(x0_s1);
		full_s2[1] <= row0_s1 + ADDR_FULL_W'(x1_s1);
		full_s2[2] <= row1_s1 + ADDR_FULL_W'(x0_s1);
		full_s2[3] <= row1_s1 + ADDR_FULL_W'(x1_s1);
	end

	if ((TEXEL_CAPACITY & (TEXEL_CAPACITY - 1)) == 0) begin : g_mask
		logic                     valid_s3;
		bas_item_t                item_s3;
		logic [3:0][ADDR_W-1:0]   addr_s3;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s3 <= 1'b0;
			end else begin
				valid_s3 <= valid_s2;
			end
		end

		always_ff @(posedge clk) begin
			item_s3 <= item_s2;
			for (int i = 0; i < 4; i++) begin
				addr_s3[i] <= full_s2[i][ADDR_W-1:0];
			end
		end

		assign out_valid = valid_s3;
		assign out_item = item_s3;
		assign out_addr = addr_s3;
	end else begin : g_fold
		logic [$bits(bas_item_t)-1:0] side_out;

		bas_rem_pipe #(
			.LANES(4),
			.DW(ADDR_FULL_W),
			.DVW(ADDR_W),
			.SW($bits(bas_item_t))
		) u_fold (
			.clk(clk),
			.arst_n(arst_n),
			.divisor({4{ADDR_W'(TEXEL_CAPACITY)}}),
			.in_valid(valid_s2),
			.dividend(full_s2),
			.in_side(item_s2),
			.out_valid(out_valid),
			.remainder(out_addr),
			.out_side(side_out)
		);

		assign out_item = bas_item_t'(side_out);
	end

endmodule

[rtl/bas_store.sv]
// ----------------------------------------------------------------------------
// bas_store: alpha texel store
// Two copies of the texture, each with two read ports, give all four
// neighbors at once; writes go to both copies in pipeline order.
// ----------------------------------------------------------------------------
module bas_store #(
	parameter int TEXEL_CAPACITY = bas_pkg::TEXEL_CAPACITY_DEF,
	localparam int ADDR_W = $clog2(TEXEL_CAPACITY)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  bas_pkg::bas_item_t      in_item,
	input  logic [3:0][ADDR_W-1:0]  in_addr,
	output logic                    out_valid,
	output bas_pkg::bas_tap_t       out_tap,
	output bas_pkg::bas_quad_t      out_quad
);
	import bas_pkg::*;

	logic [ALPHA_W-1:0] mem_a [TEXEL_CAPACITY];
	logic [ALPHA_W-1:0] mem_b [TEXEL_CAPACITY];

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic               valid_s1;
	bas_tap_t           tap_s1;
	bas_quad_t          quad_s1;

	// A write beyond the capacity is dropped.
	always_comb begin
		wr_en = in_valid && !in_item.is_sample
			&& (32'(in_item.texel_index) < 32'(TEXEL_CAPACITY));
		wr_addr = ADDR_W'(in_item.texel_index);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= in_item.texel_alpha;
			mem_b[wr_addr] <= in_item.texel_alpha;
		end
		quad_s1.a00 <= mem_a[in_addr[0]];
		quad_s1.a10 <= mem_a[in_addr[1]];
		quad_s1.a01 <= mem_b[in_addr[2]];
		quad_s1.a11 <= mem_b[in_addr[3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1.is_sample <= in_item.is_sample;
		tap_s1.frac_x <= in_item.frac_x;
		tap_s1.frac_y <= in_item.frac_y;
	end

	assign out_valid = valid_s1;
	assign out_tap = tap_s1;
	assign out_quad = quad_s1;

endmodule

[rtl/bas_blend.sv]
// ----------------------------------------------------------------------------
// bas_blend: bilinear blend
// Weights the four neighbors horizontally, then vertically, and rounds the
// sum half up to a 16-bit unorm.
// ----------------------------------------------------------------------------
module bas_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  bas_pkg::bas_tap_t             in_tap,
	input  bas_pkg::bas_quad_t            in_quad,
	output logic                          out_valid,
	output logic [bas_pkg::ALPHA_W-1:0]   out_alpha
);
	import bas_pkg::*;

	localparam int SUM_W = ACC_W + 1;
	localparam int HI_W = SUM_W - 2 * FRAC_BITS;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (2 * FRAC_BITS - 1));

	logic [WT_W-1:0]              wx0;
	logic [WT_W-1:0]              wx1;
	logic [WT_W-1:0]              wy0;
	logic [SUM_W-1:0]             sum_c;
	logic [HI_W-1:0]              hi_c;

	logic                         valid_s1;
	logic [FRAC_BITS-1:0]         ty_s1;
	logic [3:0][PROD_W-1:0]       prod_s1;

	logic                         valid_s2;
	logic [FRAC_BITS-1:0]         ty_s2;
	logic [PROD_W-1:0]            top_s2;
	logic [PROD_W-1:0]            bot_s2;

	logic                         valid_s3;
	logic [ACC_W-1:0]             qtop_s3;
	logic [ACC_W-1:0]             qbot_s3;

	logic                         valid_s4;
	logic [ALPHA_W-1:0]           alpha_s4;

	always_comb begin
		wx1 = WT_W'(in_tap.frac_x);
		wx0 = WT_ONE - wx1;
		wy0 = WT_ONE - WT_W'(ty_s2);
		sum_c = SUM_W'(qtop_s3) + SUM_W'(qbot_s3) + ROUND_HALF;
		hi_c = sum_c[SUM_W-1:2*FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_tap.is_sample;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ty_s1 <= in_tap.frac_y;
		prod_s1[0] <= PROD_W'(in_quad.a00) * PROD_W'(wx0);
		prod_s1[1] <= PROD_W'(in_quad.a10) * PROD_W'(wx1);
		prod_s1[2] <= PROD_W'(in_quad.a01) * PROD_W'(wx0);
		prod_s1[3] <= PROD_W'(in_quad.a11) * PROD_W'(wx1);

		ty_s2 <= ty_s1;
		top_s2 <= prod_s1[0] + prod_s1[1];
		bot_s2 <= prod_s1[2] + prod_s1[3];

		qtop_s3 <= ACC_W'(top_s2) * ACC_W'(wy0);
		qbot_s3 <= ACC_W'(bot_s2) * ACC_W'(ty_s2);

		if (|hi_c[HI_W-1:ALPHA_W]) begin
			alpha_s4 <= '1;
		end else begin
			alpha_s4 <= hi_c[ALPHA_W-1:0];
		end
	end

	assign out_valid = valid_s4;
	assign out_alpha = alpha_s4;

endmodule

[rtl/bilinear_alpha_sampler_wrap.sv]
// ----------------------------------------------------------------------------
// bilinear_alpha_sampler_wrap: bilinear alpha texture sampler, repeat wrap
// The sampler takes one transaction per clock, write or sample, and busy stays
// low. A sample result appears on sampled_alpha with result_valid high for one
// cycle; the result cannot be held off, so the receiver must take it in that
// cycle. Most of the pipeline lies in the wrap remainder unit, which resolves
// four bits of the scaled coordinate per stage, and in the bilinear multiply
// tree.
// Writes reach the texture store at the same pipeline point as sample reads,
// so every sample sees exactly the writes issued before it. The store is not
// cleared: texels must be written before they are sampled. Image width and
// height may only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module bilinear_alpha_sampler_wrap #(
	parameter int TEXEL_CAPACITY = bas_pkg::TEXEL_CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [bas_pkg::INDEX_W-1:0]        texel_index,
	input  logic [bas_pkg::ALPHA_W-1:0]        texel_alpha,
	input  logic signed [bas_pkg::COORD_W-1:0] coord_u,
	input  logic signed [bas_pkg::COORD_W-1:0] coord_v,
	output logic                               result_valid,
	output logic [bas_pkg::ALPHA_W-1:0]        sampled_alpha,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bas_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bas_pkg::DIM_W-1:0]          cfg_data
);
	import bas_pkg::*;

	localparam int ADDR_W = $clog2(TEXEL_CAPACITY);

	logic [DIM_W-1:0]          image_width_q;
	logic [DIM_W-1:0]          image_height_q;
	logic [DIM_W-1:0]          w_eff;
	logic [DIM_W-1:0]          h_eff;

	logic signed [XF_W-1:0]    xf_c;
	logic signed [XF_W-1:0]    yf_c;

	logic                      valid_s1;
	logic                      sample_s1;
	logic [INDEX_W-1:0]        index_s1;
	logic [ALPHA_W-1:0]        alpha_s1;
	logic signed [XF_W-1:0]    xf_s1;
	logic signed [XF_W-1:0]    yf_s1;

	logic [IC_W-1:0]           ix_c;
	logic [IC_W-1:0]           iy_c;
	logic [WRAP_W-1:0]         wrap_x_c;
	logic [WRAP_W-1:0]         wrap_y_c;
	bas_item_t                 item_c;

	logic                      valid_s2;
	bas_item_t                 item_s2;
	logic [WRAP_W-1:0]         wrap_x_s2;
	logic [WRAP_W-1:0]         wrap_y_s2;

	logic                           wrap_valid;
	logic [1:0][DIM_W-1:0]          wrap_rem;
	logic [$bits(bas_item_t)-1:0]   wrap_side;

	logic                      addr_valid;
	bas_item_t                 addr_item;
	logic [3:0][ADDR_W-1:0]    addr_addr;

	logic                      store_valid;
	bas_tap_t                  store_tap;
	bas_quad_t                 store_quad;

	// The pipeline never stalls; the user must write configuration only when idle, as the block does not enforce it.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
			endcase
		end
	end

	// A zero dimension behaves as one texel.
	always_comb begin
		w_eff = (image_width_q == '0) ? DIM_W'(1) : image_width_q;
		h_eff = (image_height_q == '0) ? DIM_W'(1) : image_height_q;
		xf_c = XF_W'(coord_u) * XF_W'($signed({1'b0, w_eff})) - FIX_HALF;
		yf_c = (FIX_ONE - XF_W'(coord_v)) * XF_W'($signed({1'b0, h_eff})) - FIX_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= (req_type == REQ_SAMPLE);
		index_s1 <= texel_index;
		alpha_s1 <= texel_alpha;
		xf_s1 <= xf_c;
		yf_s1 <= yf_c;
	end

	// The integer part is the floor of the scaled coordinate. Adding a multiple
	// of the dimension large enough to make it positive leaves the wrap unchanged.
	always_comb begin
		ix_c = xf_s1[XF_W-1:FRAC_BITS];
		iy_c = yf_s1[XF_W-1:FRAC_BITS];
		wrap_x_c = {{(WRAP_W-IC_W){ix_c[IC_W-1]}}, ix_c} + (WRAP_W'(w_eff) << (IC_W - 1));
		wrap_y_c = {{(WRAP_W-IC_W){iy_c[IC_W-1]}}, iy_c} + (WRAP_W'(h_eff) << (IC_W - 1));
		item_c.is_sample = sample_s1;
		item_c.texel_index = index_s1;
		item_c.texel_alpha = alpha_s1;
		item_c.frac_x = xf_s1[FRAC_BITS-1:0];
		item_c.frac_y = yf_s1[FRAC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_c;
		wrap_x_s2 <= wrap_x_c;
		wrap_y_s2 <= wrap_y_c;
	end

	bas_rem_pipe #(
		.LANES(2),
		.DW(WRAP_W),
		.DVW(DIM_W),
		.SW($bits(bas_item_t))
	) u_wrap (
		.clk(clk),
		.arst_n(arst_n),
		.divisor({h_eff, w_eff}),
		.in_valid(valid_s2),
		.dividend({wrap_y_s2, wrap_x_s2}),
		.in_side(item_s2),
		.out_valid(wrap_valid),
		.remainder(wrap_rem),
		.out_side(wrap_side)
	);

	bas_addr #(
		.TEXEL_CAPACITY(TEXEL_CAPACITY)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.dim_w(w_eff),
		.dim_h(h_eff),
		.in_valid(wrap_valid),
		.in_item(bas_item_t'(wrap_side)),
		.in_x0(wrap_rem[0]),
		.in_y0(wrap_rem[1]),
		.out_valid(addr_valid),
		.out_item(addr_item),
		.out_addr(addr_addr)
	);

	bas_store #(
		.TEXEL_CAPACITY(TEXEL_CAPACITY)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(addr_valid),
		.in_item(addr_item),
		.in_addr(addr_addr),
		.out_valid(store_valid),
		.out_tap(store_tap),
		.out_quad(store_quad)
	);

	bas_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(store_valid),
		.in_tap(store_tap),
		.in_quad(store_quad),
		.out_valid(result_valid),
		.out_alpha(sampled_alpha)
	);

	a_wrap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_valid |-> (wrap_rem[0] < w_eff) && (wrap_rem[1] < h_eff))
		else $error("wrapped texel coordinate outside the image");

	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid |-> (32'(addr_addr[0]) < 32'(TEXEL_CAPACITY))
			&& (32'(addr_addr[1]) < 32'(TEXEL_CAPACITY))
			&& (32'(addr_addr[2]) < 32'(TEXEL_CAPACITY))
			&& (32'(addr_addr[3]) < 32'(TEXEL_CAPACITY)))
		else $error("fetch address outside the texel store");

	a_result_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(store_valid && store_tap.is_sample, BLEND_LAT))
		else $error("result without a sample transaction at the store");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bilinear_alpha_sampler_wrap
// Runs directed and random texel writes and samples over a sweep of image
// sizes; every texel a sample will fetch is written beforehand. A built-in
// predictor of the bilinear blend with repeat wrapping checks every returned
// alpha, in order.
// ----------------------------------------------------------------------------
module testbench;
	import bas_pkg::*;

	localparam int STORE_DEPTH = 65536;
	localparam int DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	logic [INDEX_W-1:0] texel_index;
	logic [ALPHA_W-1:0] texel_alpha;
	logic signed [COORD_W-1:0] coord_u;
	logic signed [COORD_W-1:0] coord_v;
	logic result_valid;
	logic [ALPHA_W-1:0] sampled_alpha;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	// Shadow copy of the texture and of the image size registers.
	logic [ALPHA_W-1:0] texel_shadow [STORE_DEPTH];
	bit texel_written [STORE_DEPTH];
	logic [DIM_W-1:0] shadow_width;
	logic [DIM_W-1:0] shadow_height;
	logic [ALPHA_W-1:0] pending_alpha [$];

	bit gaps_on;
	int mismatches;
	int samples_sent;
	int writes_sent;
	int sizes_used;
	longint cycle_count;

	bilinear_alpha_sampler_wrap u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.texel_index(texel_index),
		.texel_alpha(texel_alpha),
		.coord_u(coord_u),
		.coord_v(coord_v),
		.result_valid(result_valid),
		.sampled_alpha(sampled_alpha),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint wrap_mod(longint c, longint n);
		longint r;
		r = c % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic logic [ALPHA_W-1:0] texel_at(longint col, longint row, longint w);
		longint addr;
		addr = row * w + col;
		return texel_shadow[addr[INDEX_W-1:0]];
	endfunction

	// Store index of neighbor k of the footprint: bit 0 picks the column, bit 1 the row.
	function automatic logic [INDEX_W-1:0] neighbor_index(logic signed [COORD_W-1:0] u,
			logic signed [COORD_W-1:0] v, int k);
		longint w, h, xf, yf, ix, iy, col, row, addr;
		w = (shadow_width == 0) ? 1 : longint'(shadow_width);
		h = (shadow_height == 0) ? 1 : longint'(shadow_height);
		xf = longint'(u) * w - 32768;
		yf = (65536 - longint'(v)) * h - 32768;
		ix = xf >>> FRAC_BITS;
		iy = yf >>> FRAC_BITS;
		col = wrap_mod(ix + longint'(k & 1), w);
		row = wrap_mod(iy + longint'((k >> 1) & 1), h);
		addr = row * w + col;
		return addr[INDEX_W-1:0];
	endfunction

	function automatic logic [ALPHA_W-1:0] blend_alpha(logic signed [COORD_W-1:0] u,
			logic signed [COORD_W-1:0] v);
		longint w, h, xf, yf, ix, iy, tx, ty;
		longint x0, x1, y0, y1, top, bot, acc;
		w = (shadow_width == 0) ? 1 : longint'(shadow_width);
		h = (shadow_height == 0) ? 1 : longint'(shadow_height);
		xf = longint'(u) * w - 32768;
		yf = (65536 - longint'(v)) * h - 32768;
		ix = xf >>> FRAC_BITS;
		iy = yf >>> FRAC_BITS;
		tx = xf - ix * 65536;
		ty = yf - iy * 65536;
		x0 = wrap_mod(ix, w);
		x1 = wrap_mod(ix + 1, w);
		y0 = wrap_mod(iy, h);
		y1 = wrap_mod(iy + 1, h);
		top = longint'(texel_at(x0, y0, w)) * (65536 - tx) + longint'(texel_at(x1, y0, w)) * tx;
		bot = longint'(texel_at(x0, y1, w)) * (65536 - tx) + longint'(texel_at(x1, y1, w)) * tx;
		acc = (top * (65536 - ty) + bot * ty + (longint'(1) << 31)) >> 32;
		if (acc > 65535)
			acc = 65535;
		return acc[ALPHA_W-1:0];
	endfunction

	// Drives one transaction and holds it until the sampler takes it.
	task automatic send_item(logic kind, logic [INDEX_W-1:0] idx, logic [ALPHA_W-1:0] alpha,
			logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
		bit taken;
		start <= 1'b1;
		req_type <= kind;
		texel_index <= idx;
		texel_alpha <= alpha;
		coord_u <= u;
		coord_v <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		if (kind == REQ_WRITE) begin
			texel_shadow[idx] = alpha;
			texel_written[idx] = 1'b1;
			writes_sent++;
		end else begin
			pending_alpha.push_back(blend_alpha(u, v));
			samples_sent++;
		end
		if (gaps_on && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// The store is not cleared, so each texel a sample fetches that is still unwritten gets a value first.
	task automatic prepare_texels(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
		logic [INDEX_W-1:0] idx;
		for (int k = 0; k < 4; k++) begin
			idx = neighbor_index(u, v, k);
			if (!texel_written[idx])
				send_item(REQ_WRITE, idx, ALPHA_W'($urandom), '0, '0);
		end
	endtask

	task automatic sample_at(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
		prepare_texels(u, v);
		send_item(REQ_SAMPLE, INDEX_W'($urandom), ALPHA_W'($urandom), u, v);
	endtask

	// Waits for the pipeline to empty, since writes leave nothing to wait on.
	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending_alpha.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [DIM_W-1:0] value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			shadow_width = value;
		else
			shadow_height = value;
	endtask

	task automatic set_image_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		drain_pipeline();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		sizes_used++;
	endtask

	function automatic logic signed [COORD_W-1:0] random_coord();
		if ($urandom_range(99) < 25)
			return COORD_W'($urandom);
		return COORD_W'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
	endfunction

	task automatic test_directed();
		set_image_size(DIM_W'(4), DIM_W'(4));
		send_item(REQ_WRITE, INDEX_W'(0), 16'h0000, '0, '0);
		send_item(REQ_WRITE, INDEX_W'(1), 16'hFFFF, '0, '0);
		send_item(REQ_WRITE, INDEX_W'(16'hFFFF), 16'hFFFF, '0, '0);
		send_item(REQ_WRITE, INDEX_W'(5), 16'h8000, '0, '0);
		sample_at(24'sd0, 24'sd0);
		sample_at(24'sd65536, 24'sd65536);
		sample_at(24'sd8192, 24'sd57344);
		sample_at(24'sd32768, 24'sd32768);
		sample_at(24'sh7FFFFF, 24'sh7FFFFF);
		sample_at(-24'sd8388608, -24'sd8388608);
		sample_at(24'sh7FFFFF, -24'sd8388608);
		sample_at(-24'sd1, 24'sd1);
		sample_at(-24'sd65536, 24'sd131072);
		sample_at(24'sd12345, -24'sd54321);
		// Zero width and height behave like a single texel.
		set_image_size('0, '0);
		sample_at(24'sd40000, 24'sd20000);
		sample_at(-24'sd1, 24'sh7FFFFF);
		// Largest dimensions make fetch addresses run past the store.
		set_image_size(DIM_W'(2047), DIM_W'(2047));
		sample_at(24'sh7FFFFF, 24'sd3);
		sample_at(-24'sd8388608, 24'sh7FFFFF);
		sample_at(24'sd65535, 24'sd1);
	endtask

	task automatic test_size_sweep();
		int dims [8][2] = '{'{1, 1}, '{1024, 1024}, '{1, 1024}, '{1024, 1}, '{7, 3},
				'{256, 256}, '{2047, 1}, '{3, 5}};
		for (int s = 0; s < 8; s++) begin
			set_image_size(DIM_W'(dims[s][0]), DIM_W'(dims[s][1]));
			for (int k = 0; k < 5; k++)
				sample_at(random_coord(), random_coord());
		end
	endtask

	task automatic test_random_traffic();
		int w, h;
		for (int n = 0; n < 240; n++) begin
			if (n % 40 == 0) begin
				if ($urandom_range(9) < 8) begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 16);
				end else begin
					w = $urandom_range(0, 2047);
					h = $urandom_range(0, 2047);
				end
				set_image_size(DIM_W'(w), DIM_W'(h));
			end
			gaps_on = !(n >= 100 && n < 160);
			if ($urandom_range(99) < 35)
				send_item(REQ_WRITE, INDEX_W'($urandom), ALPHA_W'($urandom),
						COORD_W'($urandom), COORD_W'($urandom));
			else
				sample_at(random_coord(), random_coord());
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_alpha.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: sampled_alpha=%h", sampled_alpha);
			end else begin
				if (sampled_alpha !== pending_alpha[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: sampled_alpha expected %h actual %h",
								pending_alpha[0], sampled_alpha);
				end
				void'(pending_alpha.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** bilinear_alpha_sampler_wrap: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WRITE;
		texel_index = '0;
		texel_alpha = '0;
		coord_u = '0;
		coord_v = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		shadow_width = DIM_W'(1);
		shadow_height = DIM_W'(1);
		mismatches = 0;
		samples_sent = 0;
		writes_sent = 0;
		sizes_used = 0;
		cycle_count = 0;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_sweep();
		test_random_traffic();
		drain_pipeline();
		if (pending_alpha.size() != 0)
			mismatches++;
		$display("Covered %0d texel writes and %0d samples over %0d image sizes.",
				writes_sent, samples_sent, sizes_used);
		if (mismatches == 0) begin
			$display("** bilinear_alpha_sampler_wrap: PASSED **");
		end else begin
			$display("%0d mismatches found", mismatches);
			$display("** bilinear_alpha_sampler_wrap: FAILED **");
		end
		$finish;
	end

endmodule
